FILE: rtl/bcgf_pkg.sv
// Shared types and constants for the bilinear corner grid fill block.
package bcgf_pkg;

  // Largest extent along either axis; written extents clamp to 1..MAX_SIDE
  localparam int MAX_SIDE = 64;

  // Field widths
  localparam int CRN_W  = 12;  // corner height
  localparam int EXT_W  = 7;   // extent register
  localparam int CRD_W  = 6;   // cell coordinate
  localparam int HGT_W  = 14;  // result height
  localparam int CFG_AW = 3;   // config register index
  localparam int CFG_DW = 12;  // config write data

  // Datapath widths
  localparam int WGT_W  = 14;  // corner weight, signed, -3968..4096
  localparam int DEN_W  = 13;  // X*Z, up to 4096
  localparam int PROD_W = 25;  // weight times corner, signed
  localparam int NUM_W  = 27;  // sum of four products, signed
  localparam int MAG_W  = 26;  // magnitude of the sum
  localparam int DVD_W  = 28;  // dividend 2*mag + den
  localparam int DVS_W  = 14;  // divisor 2*den
  localparam int QUO_W  = 14;  // rounded quotient bits kept

  // Saturation limits of the height field
  localparam logic [HGT_W-1:0] HGT_MAX   = 14'h1FFF;
  localparam logic [HGT_W-1:0] HGT_MIN   = 14'h2000;
  localparam logic [QUO_W-1:0] QUO_POS_L = 14'd8191;
  localparam logic [QUO_W-1:0] QUO_NEG_L = 14'd8192;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_CORNER_LL = 3'd0,
    REG_CORNER_LH = 3'd1,
    REG_CORNER_HL = 3'd2,
    REG_CORNER_HH = 3'd3,
    REG_EXTENT_X  = 3'd4,
    REG_EXTENT_Z  = 3'd5
  } cfg_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic [CRN_W-1:0] corner_low_low;
    logic [CRN_W-1:0] corner_low_high;
    logic [CRN_W-1:0] corner_high_low;
    logic [CRN_W-1:0] corner_high_high;
    logic [EXT_W-1:0] extent_x;
    logic [EXT_W-1:0] extent_z;
  } cfg_t;

  // Weighted sum handed to the divider
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } sum_t;

  // Rounded quotient handed to the output stage
  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             neg;
  } quo_t;

endpackage

FILE: rtl/bcgf_if.sv
// Valid/ready channel interfaces for cell coordinates and result heights.
interface bcgf_in_if;
  logic                         valid;
  logic                         ready;
  logic [bcgf_pkg::CRD_W-1:0]   cell_x;
  logic [bcgf_pkg::CRD_W-1:0]   cell_z;

  modport source (output valid, output cell_x, output cell_z, input ready);
  modport sink   (input valid, input cell_x, input cell_z, output ready);
endinterface

interface bcgf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bcgf_pkg::HGT_W-1:0] height;
  logic                              saturated;

  modport source (output valid, output height, output saturated, input ready);
  modport sink   (input valid, input height, input saturated, output ready);
endinterface

FILE: rtl/bcgf_weight.sv
// Three-stage front end: corner weights, weighted corners, and their sum.
module bcgf_weight (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bcgf_pkg::cfg_t             cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [bcgf_pkg::CRD_W-1:0] up_x,
  input  logic [bcgf_pkg::CRD_W-1:0] up_z,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output bcgf_pkg::sum_t             dn_sum
);
  import bcgf_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld_r;
  logic            adv;

  // Stage 1: bilinear weights and denominator
  logic signed [7:0]       ax, az, sx, sz;
  logic signed [15:0]      m00, m10, m01, m11;
  logic [2*EXT_W-1:0]      dprod;
  logic signed [WGT_W-1:0] w00_r, w10_r, w01_r, w11_r;
  logic [DEN_W-1:0]        den1_r;

  // Stage 2: weight times corner height
  logic signed [NUM_W-1:0]  p00, p10, p01, p11;
  logic signed [PROD_W-1:0] p00_r, p10_r, p01_r, p11_r;
  logic [DEN_W-1:0]         den2_r;

  // Stage 3: sum of the four terms
  logic signed [NUM_W-1:0] num_nxt;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den3_r;

  // Advance the whole front end unless its last stage is blocked
  assign adv      = !vld_r[NSTG-1] || dn_ready;
  assign up_ready = adv;
  assign dn_valid = vld_r[NSTG-1];
  assign dn_sum   = '{num: num_r, den: den3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], up_valid};
    end
  end

  // Distances to the far corners; negative past the extent
  always_comb begin
    sx    = signed'({2'b00, up_x});
    sz    = signed'({2'b00, up_z});
    ax    = signed'({1'b0, cfg.extent_x} - {2'b00, up_x});
    az    = signed'({1'b0, cfg.extent_z} - {2'b00, up_z});
    m00   = ax * az;
    m10   = sx * az;
    m01   = ax * sz;
    m11   = sx * sz;
    dprod = cfg.extent_x * cfg.extent_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w00_r  <= m00[WGT_W-1:0];
      w10_r  <= m10[WGT_W-1:0];
      w01_r  <= m01[WGT_W-1:0];
      w11_r  <= m11[WGT_W-1:0];
      den1_r <= dprod[DEN_W-1:0];
    end
  end

  // Scale each weight by its corner height
  always_comb begin
    p00 = w00_r * signed'({1'b0, cfg.corner_low_low});
    p10 = w10_r * signed'({1'b0, cfg.corner_high_low});
    p01 = w01_r * signed'({1'b0, cfg.corner_low_high});
    p11 = w11_r * signed'({1'b0, cfg.corner_high_high});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p00_r  <= p00[PROD_W-1:0];
      p10_r  <= p10[PROD_W-1:0];
      p01_r  <= p01[PROD_W-1:0];
      p11_r  <= p11[PROD_W-1:0];
      den2_r <= den1_r;
    end
  end

  // Add the four weighted corners
  assign num_nxt = NUM_W'(p00_r) + NUM_W'(p10_r) + NUM_W'(p01_r) + NUM_W'(p11_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= num_nxt;
      den3_r <= den2_r;
    end
  end

endmodule

FILE: rtl/bcgf_div.sv
// Pipelined restoring divider: one quotient bit per stage, rounding folded in.
module bcgf_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  bcgf_pkg::sum_t up_sum,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bcgf_pkg::quo_t dn_quo
);
  import bcgf_pkg::*;

  localparam int NSTG = QUO_W + 1;

  logic [NSTG-1:0] vld_r;
  logic            adv;

  // Prep stage signals
  logic                    neg;
  logic signed [NUM_W-1:0] absn;
  logic [MAG_W-1:0]        mag;
  logic [DVD_W-1:0]        dvd;
  logic [DVS_W-1:0]        dvs;
  logic                    ovf;

  // Per-stage state; stage 0 is the prep register
  logic [DVD_W-1:0] rem_r [0:QUO_W-1];
  logic [DVS_W-1:0] dvs_r [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic             neg_r [0:QUO_W];

  // Advance all stages together unless the last one is blocked
  assign adv      = !vld_r[NSTG-1] || dn_ready;
  assign up_ready = adv;
  assign dn_valid = vld_r[NSTG-1];
  assign dn_quo   = '{quo: quo_r[QUO_W], ovf: ovf_r[QUO_W], neg: neg_r[QUO_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], up_valid};
    end
  end

  // Round half away from zero: divide 2*|num| + den by 2*den
  always_comb begin
    neg  = up_sum.num[NUM_W-1];
    absn = neg ? -up_sum.num : up_sum.num;
    mag  = absn[MAG_W-1:0];
    dvd  = DVD_W'({mag, 1'b0}) + DVD_W'(up_sum.den);
    dvs  = {up_sum.den, 1'b0};
    ovf  = dvd >= (DVD_W'(dvs) << QUO_W);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= dvd;
      dvs_r[0] <= dvs;
      quo_r[0] <= '0;
      ovf_r[0] <= ovf;
      neg_r[0] <= neg;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - j;
    logic [DVD_W-1:0] sub;
    logic             take;

    always_comb begin
      sub  = DVD_W'(dvs_r[j-1]) << K;
      take = rem_r[j-1] >= sub;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[j] <= quo_r[j-1] | (take ? (QUO_W'(1) << K) : '0);
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end

    if (j < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= take ? (rem_r[j-1] - sub) : rem_r[j-1];
          dvs_r[j] <= dvs_r[j-1];
        end
      end
    end
  end

endmodule

FILE: rtl/bcgf_round.sv
// Output register: apply sign, saturate and present the result beat.
module bcgf_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  bcgf_pkg::quo_t    up_quo,
  bcgf_out_if.source        out_ch
);
  import bcgf_pkg::*;

  logic             vld_r;
  logic             adv;
  logic [HGT_W-1:0] hgt_nxt;
  logic             sat_nxt;
  logic [HGT_W-1:0] hgt_r;
  logic             sat_r;

  // Take a new beat when the register is empty or being drained
  assign adv          = !vld_r || out_ch.ready;
  assign up_ready     = adv;
  assign out_ch.valid = vld_r;
  assign out_ch.height    = signed'(hgt_r);
  assign out_ch.saturated = sat_r;

  // Clamp to the height range and flag it
  always_comb begin
    hgt_nxt = up_quo.quo;
    sat_nxt = 1'b0;
    if (up_quo.neg) begin
      if (up_quo.ovf || (up_quo.quo > QUO_NEG_L)) begin
        hgt_nxt = HGT_MIN;
        sat_nxt = 1'b1;
      end else begin
        hgt_nxt = -up_quo.quo;
      end
    end else if (up_quo.ovf || (up_quo.quo > QUO_POS_L)) begin
      hgt_nxt = HGT_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hgt_r <= hgt_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

FILE: rtl/bilinear_corner_grid_fill.sv
// Top level: configuration registers and the bilinear interpolation pipeline.
//
// Usage:
//   in_ch carries one cell coordinate (cell_x, cell_z) per beat; out_ch returns
//   one beat per input with the interpolated height, rounded half away from
//   zero, and a saturated flag when the rounded value left -8192..8191.
//   The cfg port writes corner heights (indexes 0..3) and the extents X and Z
//   (indexes 4 and 5) when cfg_we is high; extents clamp to
//   1..64 and indexes past the list are dropped. Write it only while idle.
// Path: an accepted input beat passes three stages of weights, products and
//   sum, one divider prep stage, 14 divider stages (one quotient bit each),
//   and the output register before its result appears on out_ch.
// Throughput: one beat per cycle when out_ch does not stall; every stage is
//   registered and the divider fully unrolled, so a new cell enters each cycle.
// Reset (rst_n low, synchronous) empties the pipeline, sets the corners to 0
//   and both extents to 16.
// Stall: when out_ch.ready is low the result holds; each section keeps taking
//   beats while its last stage is empty, then in_ch.ready drops.
module bilinear_corner_grid_fill (
  input  logic                        clk,
  input  logic                        rst_n,
  bcgf_in_if.sink                     in_ch,
  bcgf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [bcgf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bcgf_pkg::CFG_DW-1:0] cfg_data
);
  import bcgf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  logic wt_valid, wt_ready;
  sum_t wt_sum;
  logic dv_valid, dv_ready;
  quo_t dv_quo;

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [CFG_DW-1:0] v);
    logic [EXT_W-1:0] e;
    e = v[EXT_W-1:0];
    if (e == '0) begin
      e = EXT_W'(1);
    end else if (e > EXT_W'(MAX_SIDE)) begin
      e = EXT_W'(MAX_SIDE);
    end
    return e;
  endfunction

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CORNER_LL: cfg_nxt.corner_low_low   = cfg_data[CRN_W-1:0];
        REG_CORNER_LH: cfg_nxt.corner_low_high  = cfg_data[CRN_W-1:0];
        REG_CORNER_HL: cfg_nxt.corner_high_low  = cfg_data[CRN_W-1:0];
        REG_CORNER_HH: cfg_nxt.corner_high_high = cfg_data[CRN_W-1:0];
        REG_EXTENT_X:  cfg_nxt.extent_x         = clamp_ext(cfg_data);
        REG_EXTENT_Z:  cfg_nxt.extent_z         = clamp_ext(cfg_data);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{corner_low_low: '0, corner_low_high: '0,
                 corner_high_low: '0, corner_high_high: '0,
                 extent_x: EXT_W'(16), extent_z: EXT_W'(16)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Weights, products and sum
  bcgf_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_x     (in_ch.cell_x),
    .up_z     (in_ch.cell_z),
    .dn_valid (wt_valid),
    .dn_ready (wt_ready),
    .dn_sum   (wt_sum)
  );

  // Rounded division by X*Z
  bcgf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (wt_valid),
    .up_ready (wt_ready),
    .up_sum   (wt_sum),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_quo   (dv_quo)
  );

  // Sign, saturation and output register
  bcgf_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv_valid),
    .up_ready (dv_ready),
    .up_quo   (dv_quo),
    .out_ch   (out_ch)
  );

endmodule

FILE: tb/tb.sv
// Self-checking bench for the bilinear corner grid fill block.
module tb;
  import bcgf_pkg::*;

  localparam int     CLK_HALF          = 6;
  localparam int     RST_CYCLES        = 11;
  localparam int     PIPE_LAT          = 19;
  localparam int     CELLS_PER_SETTING = 71;
  localparam int     SETTINGS_PER_MODE = 3;
  localparam longint HEIGHT_TOP        = (longint'(1) << (HGT_W - 1)) - 1;
  localparam longint HEIGHT_BOTTOM     = -(longint'(1) << (HGT_W - 1));
  localparam int     CORNER_TOP        = (1 << CRN_W) - 1;
  localparam int     COORD_TOP         = (1 << CRD_W) - 1;

  // Register indexes past the list; writes there must be dropped
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pacing_t;

  typedef struct {
    logic signed [HGT_W-1:0] height;
    logic                    saturated;
  } cell_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;

  bcgf_in_if  in_ch();
  bcgf_out_if out_ch();

  bilinear_corner_grid_fill dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the register file
  int crn_ll;
  int crn_lh;
  int crn_hl;
  int crn_hh;
  int span_x;
  int span_z;

  cell_result_t pending_heights[$];

  int idle_pct;
  int stall_pct;
  int fail_count;
  int cells_sent;
  int heights_checked;
  int sat_count;
  int reg_writes;

  // Clamp a written extent to 1..MAX_SIDE after keeping its register bits
  function automatic int clamp_span(input logic [CFG_DW-1:0] data);
    int e;
    e = int'(data[EXT_W-1:0]);
    if (e < 1) e = 1;
    if (e > MAX_SIDE) e = MAX_SIDE;
    return e;
  endfunction

  // Exact weighted corner sum, divided with rounding half away from zero, then saturated
  function automatic cell_result_t interp_height(input logic [CRD_W-1:0] x,
                                                 input logic [CRD_W-1:0] z);
    longint       cx;
    longint       cz;
    longint       ax;
    longint       az;
    longint       num;
    longint       den;
    longint       mag;
    longint       q;
    cell_result_t r;
    cx  = longint'(x);
    cz  = longint'(z);
    ax  = span_x - cx;
    az  = span_z - cz;
    num = ax * az * crn_ll + cx * az * crn_hl + ax * cz * crn_lh + cx * cz * crn_hh;
    den = longint'(span_x) * span_z;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    r.saturated = 1'b0;
    if (q > HEIGHT_TOP) begin
      q = HEIGHT_TOP;
      r.saturated = 1'b1;
    end else if (q < HEIGHT_BOTTOM) begin
      q = HEIGHT_BOTTOM;
      r.saturated = 1'b1;
    end
    r.height = q[HGT_W-1:0];
    return r;
  endfunction

  function automatic int pick_corner();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return CORNER_TOP;
      default: return int'($urandom_range(0, CORNER_TOP));
    endcase
  endfunction

  // Mostly legal extents, sometimes raw data that has to clamp
  function automatic int pick_extent();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return MAX_SIDE;
      2: return int'($urandom_range(0, (1 << CFG_DW) - 1));
      3: return int'($urandom_range(1, 4));
      default: return int'($urandom_range(1, MAX_SIDE));
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop if the pipeline hangs
  initial begin
    #(2 * CLK_HALF * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Compare each result beat with the oldest prediction; randomize sink ready
  initial begin
    cell_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_heights.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, got height %0d sat %0b",
                   $time, out_ch.height, out_ch.saturated);
        end else begin
          want = pending_heights.pop_front();
          heights_checked++;
          if (want.saturated) sat_count++;
          if (out_ch.height !== want.height) begin
            fail_count++;
            $display("%0t: height mismatch, expected %0d, got %0d",
                     $time, want.height, out_ch.height);
          end
          if (out_ch.saturated !== want.saturated) begin
            fail_count++;
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, out_ch.saturated);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Write one register and track it in the shadow copy
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int data);
    logic [CFG_DW-1:0] word;
    word = CFG_DW'(data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_CORNER_LL: crn_ll = int'(word[CRN_W-1:0]);
      REG_CORNER_LH: crn_lh = int'(word[CRN_W-1:0]);
      REG_CORNER_HL: crn_hl = int'(word[CRN_W-1:0]);
      REG_CORNER_HH: crn_hh = int'(word[CRN_W-1:0]);
      REG_EXTENT_X:  span_x = clamp_span(word);
      REG_EXTENT_Z:  span_z = clamp_span(word);
      default: ;
    endcase
  endtask

  task automatic set_corners(input int ll, input int lh, input int hl, input int hh);
    write_reg(REG_CORNER_LL, ll);
    write_reg(REG_CORNER_LH, lh);
    write_reg(REG_CORNER_HL, hl);
    write_reg(REG_CORNER_HH, hh);
  endtask

  task automatic set_extents(input int ex, input int ez);
    write_reg(REG_EXTENT_X, ex);
    write_reg(REG_EXTENT_Z, ez);
  endtask

  // Send one cell beat; valid stays high on return so back-to-back beats need no bubble
  task automatic send_cell(input int x, input int z);
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cz;
    cx = CRD_W'(x);
    cz = CRD_W'(z);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cell_x <= cx;
    in_ch.cell_z <= cz;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_heights.insert(pending_heights.size(), interp_height(cx, cz));
    cells_sent++;
  endtask

  // Drop valid and hold until every predicted height has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
  endtask

  task automatic set_pacing(input pacing_t mode);
    case (mode)
      PACE_FREE:        begin idle_pct = 0;  stall_pct = 0;  end
      PACE_SENDER_IDLE: begin idle_pct = 71; stall_pct = 0;  end
      PACE_SINK_STALL:  begin idle_pct = 0;  stall_pct = 71; end
      PACE_BOTH:        begin idle_pct = 38; stall_pct = 38; end
      default: ;
    endcase
  endtask

  // Reset values: flat zero surface over a 16 by 16 span
  task automatic test_reset_defaults();
    send_cell(0, 0);
    send_cell(COORD_TOP, COORD_TOP);
    send_cell(8, 8);
    wait_idle();
  endtask

  // Corners only, extents left at reset, then the widest span
  task automatic test_corner_weights();
    set_corners(CORNER_TOP, 0, 0, CORNER_TOP);
    send_cell(8, 8);
    send_cell(16, 16);
    send_cell(0, 16);
    wait_idle();
    set_corners(CORNER_TOP, CORNER_TOP, CORNER_TOP, CORNER_TOP);
    set_extents(MAX_SIDE, MAX_SIDE);
    send_cell(0, 0);
    send_cell(COORD_TOP, COORD_TOP);
    send_cell(COORD_TOP, 0);
    wait_idle();
  endtask

  // Unit span with far cells: extrapolation past both height limits
  task automatic test_saturation();
    set_corners(CORNER_TOP, 0, 0, CORNER_TOP);
    set_extents(1, 1);
    send_cell(COORD_TOP, 0);
    send_cell(COORD_TOP, COORD_TOP);
    send_cell(1, 1);
    wait_idle();
  endtask

  // Values exactly halfway between integers, both signs
  task automatic test_rounding_ties();
    set_corners(0, 0, 1, 0);
    set_extents(2, 1);
    send_cell(1, 0);
    send_cell(3, 0);
    wait_idle();
    set_corners(1, 0, 0, 0);
    send_cell(3, 0);
    send_cell(5, 0);
    wait_idle();
  endtask

  // Zero and oversized extents clamp; spare indexes are dropped
  task automatic test_extent_clamp();
    set_corners(100, 200, 300, 400);
    set_extents(0, 'h0FF);
    send_cell(1, 1);
    wait_idle();
    set_extents('h080, 65);
    write_reg(REG_SPARE_LO, 'hFFF);
    write_reg(REG_SPARE_HI, 'hFFF);
    send_cell(2, 3);
    send_cell(COORD_TOP, COORD_TOP);
    wait_idle();
  endtask

  // Random settings and cells under each pacing mode, with one drain mid-stream per setting
  task automatic test_random_cells();
    pacing_t modes[4];
    int      pause_at;
    int      x;
    int      z;
    modes = '{PACE_FREE, PACE_SENDER_IDLE, PACE_SINK_STALL, PACE_BOTH};
    foreach (modes[m]) begin
      set_pacing(modes[m]);
      for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
        wait_idle();
        set_corners(pick_corner(), pick_corner(), pick_corner(), pick_corner());
        set_extents(pick_extent(), pick_extent());
        pause_at = int'($urandom_range(5, CELLS_PER_SETTING - 5));
        for (int n = 0; n < CELLS_PER_SETTING; n++) begin
          if (n == pause_at) wait_idle();
          // Mostly cells inside the span, the rest anywhere
          if ($urandom_range(0, 3) != 0) begin
            x = int'($urandom_range(0, (span_x > COORD_TOP) ? COORD_TOP : span_x));
            z = int'($urandom_range(0, (span_z > COORD_TOP) ? COORD_TOP : span_z));
          end else begin
            x = int'($urandom_range(0, COORD_TOP));
            z = int'($urandom_range(0, COORD_TOP));
          end
          send_cell(x, z);
        end
      end
    end
  endtask

  // Test sequence
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cell_x <= '0;
    in_ch.cell_z <= '0;
    crn_ll = 0;
    crn_lh = 0;
    crn_hl = 0;
    crn_hh = 0;
    span_x = 16;
    span_z = 16;
    set_pacing(PACE_FREE);
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_corner_weights();
    test_saturation();
    test_rounding_ties();
    test_extent_clamp();
    test_random_cells();

    wait_idle();
    repeat (PIPE_LAT + 8) @(posedge clk);

    $display("Summary: %0d cells sent, %0d heights checked, %0d saturated, %0d writes.",
             cells_sent, heights_checked, sat_count, reg_writes);
    $display("Covered corner extremes, rounding ties, extent clamps and free, idle and stall pacing.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bcgf_pkg.sv
rtl/bcgf_if.sv
rtl/bcgf_weight.sv
rtl/bcgf_div.sv
rtl/bcgf_round.sv
rtl/bilinear_corner_grid_fill.sv
tb/tb.sv
